// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CLFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/clft_pkg.sv
package clft_pkg;

  localparam int CFG_W = 12;
  localparam logic [CFG_W-1:0] MAX_LINE_RESET = 12'd512;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [3:0] PIDX_MAX = 4'd15;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_PREFIX,
    PH_CMD,
    PH_SEP,
    PH_MIDDLE,
    PH_TRAIL
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CMD      = 3'd0,
    KIND_MIDDLE   = 3'd1,
    KIND_TRAIL    = 3'd2,
    KIND_LINE_END = 3'd3,
    KIND_DROP     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    kind_t      token_kind;
    logic       token_start;
    logic [3:0] param_index;
    logic       last;
  } res_t;

  // All results caused by one request: one or two.
  typedef struct packed {
    res_t res0;
    res_t res1;
    logic two;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: design/clft_in_if.sv
interface clft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/clft_out_if.sv
interface clft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic [2:0] token_kind;
  logic       token_start;
  logic [3:0] param_index;
  logic       last;

  modport source (output valid, output out_byte, output has_byte, output token_kind,
                  output token_start, output param_index, output last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input token_kind,
                input token_start, input param_index, input last, output ready);
endinterface

// File: design/clft_front.sv
module clft_front #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  clft_in_if.sink               in_s,
  input  logic                  cfg_we,
  input  logic [clft_pkg::CFG_W-1:0] cfg_wdata,
  input  clft_pkg::q_stat_t     qstat,
  output logic                  push,
  output clft_pkg::job_t        push_job
);
  import clft_pkg::*;

  localparam int CW = ((LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W) + 1;
  localparam logic [CW-1:0] CAP = {{(CW-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

  typedef struct packed {
    phase_t     phase;
    logic       fresh;
    logic [3:0] pcount;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    logic    emit;
    res_t    res;
  } step_t;

  localparam pstate_t RESTART = '{phase: PH_LINE_START, fresh: 1'b1, pcount: 4'd0};

  function automatic logic [3:0] sat_inc(logic [3:0] v);
    return (v == PIDX_MAX) ? PIDX_MAX : v + 4'd1;
  endfunction

  function automatic res_t mk_res(logic [7:0] ch, kind_t kind, logic start, logic [3:0] idx);
    res_t r;
    r.out_byte    = ch;
    r.has_byte    = 1'b1;
    r.token_kind  = kind;
    r.token_start = start;
    r.param_index = idx;
    r.last        = 1'b0;
    return r;
  endfunction

  // One ordinary (non-LF) byte through the tokenizer.
  function automatic step_t plain_step(pstate_t s, logic [7:0] b);
    step_t      r;
    phase_t     ph;
    logic [7:0] ch;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    ph     = s.phase;
    ch     = b;
    if (ph == PH_LINE_START && b == CH_COLON) begin
      r.st.phase = PH_PREFIX;
    end else begin
      if (ph == PH_LINE_START) begin
        ph = PH_CMD;
      end
      r.st.phase = ph;
      unique case (ph)
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            r.st.phase = PH_CMD;
            r.st.fresh = 1'b1;
          end
        end
        PH_CMD: begin
          if (b == CH_SPACE) begin
            r.st.phase = PH_SEP;
            r.st.fresh = 1'b1;
          end else begin
            if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
              ch = b - CASE_DIFF;
            end
            r.emit     = 1'b1;
            r.res      = mk_res(ch, KIND_CMD, s.fresh, 4'd0);
            r.st.fresh = 1'b0;
          end
        end
        PH_SEP: begin
          if (b == CH_COLON) begin
            r.st.phase = PH_TRAIL;
            r.st.fresh = 1'b1;
          end else if (b != CH_SPACE) begin
            r.st.phase = PH_MIDDLE;
            r.st.fresh = 1'b0;
            r.emit     = 1'b1;
            r.res      = mk_res(b, KIND_MIDDLE, 1'b1, s.pcount);
          end
        end
        PH_MIDDLE: begin
          if (b == CH_SPACE) begin
            r.st.pcount = sat_inc(s.pcount);
            r.st.phase  = PH_SEP;
            r.st.fresh  = 1'b1;
          end else begin
            r.emit     = 1'b1;
            r.res      = mk_res(b, KIND_MIDDLE, s.fresh, s.pcount);
            r.st.fresh = 1'b0;
          end
        end
        PH_TRAIL: begin
          r.emit     = 1'b1;
          r.res      = mk_res(b, KIND_TRAIL, s.fresh, s.pcount);
          r.st.fresh = 1'b0;
        end
        default: begin
          r.st = RESTART;
        end
      endcase
    end
    return r;
  endfunction

  logic [CFG_W-1:0]       max_line_r;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   cr_r, cr_nxt;
  pstate_t                st_r, st_nxt;

  logic          accept;
  logic [CW-1:0] limit, len_inc;
  logic          drop;
  step_t         s1, s2;
  logic [3:0]    cnt;

  assign in_s.ready = !qstat.full;
  assign accept     = in_s.valid && in_s.ready;

  assign limit   = ({{(CW-CFG_W){1'b0}}, max_line_r} < CAP) ?
                   {{(CW-CFG_W){1'b0}}, max_line_r} : CAP;
  assign len_inc = {{(CW-LENGTH_BITS){1'b0}}, len_r} + {{(CW-1){1'b0}}, 1'b1};
  assign drop    = len_inc > limit;

  always_comb begin
    s1.st   = st_r;
    s1.emit = 1'b0;
    s1.res  = '0;
    if (cr_r) begin
      s1 = plain_step(st_r, CH_CR);
    end
    if (in_s.rx_byte == CH_CR) begin
      s2.st   = s1.st;
      s2.emit = 1'b0;
      s2.res  = '0;
    end else begin
      s2 = plain_step(s1.st, in_s.rx_byte);
    end
    cnt = (st_r.phase == PH_MIDDLE || st_r.phase == PH_TRAIL) ? sat_inc(st_r.pcount)
                                                                : st_r.pcount;
    len_nxt  = len_r;
    cr_nxt   = cr_r;
    st_nxt   = st_r;
    push     = 1'b0;
    push_job = '0;
    if (drop) begin
      push_job.res0.token_kind  = KIND_DROP;
      push_job.res0.token_start = 1'b1;
      push_job.res0.last        = 1'b1;
      push   = accept;
      len_nxt = '0;
      cr_nxt  = 1'b0;
      st_nxt  = RESTART;
    end else if (in_s.rx_byte == CH_LF) begin
      push_job.res0.token_kind  = KIND_LINE_END;
      push_job.res0.token_start = 1'b1;
      push_job.res0.param_index = cnt;
      push_job.res0.last        = 1'b1;
      push   = accept;
      len_nxt = '0;
      cr_nxt  = 1'b0;
      st_nxt  = RESTART;
    end else begin
      len_nxt = len_inc[LENGTH_BITS-1:0];
      cr_nxt  = (in_s.rx_byte == CH_CR);
      st_nxt  = s2.st;
      push_job.two  = s1.emit && s2.emit;
      push_job.res0 = s1.emit ? s1.res : s2.res;
      push_job.res1 = s2.res;
      if (push_job.two) begin
        push_job.res1.last = 1'b1;
      end else begin
        push_job.res0.last = 1'b1;
      end
      push = accept && (s1.emit || s2.emit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= MAX_LINE_RESET;
      len_r      <= '0;
      cr_r       <= 1'b0;
      st_r       <= RESTART;
    end else begin
      if (cfg_we) begin
        max_line_r <= cfg_wdata;
      end
      if (accept) begin
        len_r <= len_nxt;
        cr_r  <= cr_nxt;
        st_r  <= st_nxt;
      end
    end
  end

endmodule

// File: design/clft_queue.sv
`include "assert_macros.svh"

module clft_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clft_pkg::job_t    push_job,
  input  logic              pop,
  output clft_pkg::job_t    head,
  output clft_pkg::q_stat_t stat
);
  import clft_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `CLFT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `CLFT_ASSERT_IMPL(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
  `CLFT_ASSERT_NEXT(a_cnt_up, rst_n && push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count not advanced on push")

endmodule

// File: design/clft_back.sv
module clft_back (
  input  logic              clk,
  input  logic              rst_n,
  input  clft_pkg::job_t    head,
  input  clft_pkg::q_stat_t qstat,
  output logic              pop,
  clft_out_if.source        out_m
);
  import clft_pkg::*;

  logic sel_r, sel_nxt;
  logic fire;
  res_t cur;

  assign cur  = sel_r ? head.res1 : head.res0;
  assign fire = out_m.valid && out_m.ready;
  assign pop  = fire && (!head.two || sel_r);

  always_comb begin
    sel_nxt = sel_r;
    if (fire) begin
      sel_nxt = head.two && !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign out_m.valid       = !qstat.empty;
  assign out_m.out_byte    = cur.out_byte;
  assign out_m.has_byte    = cur.has_byte;
  assign out_m.token_kind  = cur.token_kind;
  assign out_m.token_start = cur.token_start;
  assign out_m.param_index = cur.param_index;
  assign out_m.last        = cur.last;

endmodule

// File: design/chat_line_framer_and_tokenizer.sv
// Results: a request's results are queued on accept and offered on out_ from the queue.
// Throughput: one byte per cycle in while the queue has room; results leave one per
//   cycle while out_m is ready; a four-entry queue absorbs a held-CR flush's two results.
// Reset: rst_n low (synchronous) clears the parser to line start, the limit to 512
//   and empties the queue.
module chat_line_framer_and_tokenizer #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  clft_in_if.sink                    in_s,
  clft_out_if.source                 out_m,
  input  logic                       cfg_we,
  input  logic [clft_pkg::CFG_W-1:0] cfg_wdata
);
  import clft_pkg::*;

  // Front/back split: the front takes one byte per request, updates the
  // line length, held CR and token state, and packs the one or two results
  // of that byte into a job. The queue between them lets the output side
  // stall without stopping the byte stream until the queue fills.
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t qstat;

  // Front: framing, length check, tokenizer state machine, limit register.
  clft_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  // Hold jobs; drop nothing, reorder nothing.
  clft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  // Back: serialize each job, first result then second, and advance the
  // queue only after the job's last result is taken.
  clft_back u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .head (head),
    .qstat(qstat),
    .pop  (pop),
    .out_m(out_m)
  );

endmodule
